/* rtl/chiral_volume_penalty_gradient_assert.svh */
// Assertion macros shared by the chiral volume penalty modules.
`ifndef CHIRAL_VOLUME_PENALTY_GRADIENT_ASSERT_SVH
`define CHIRAL_VOLUME_PENALTY_GRADIENT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CVPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define CVPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cvpg_pkg.sv */
// Shared types, codes and operand tables of the chiral volume penalty block.
`timescale 1ns / 1ps
package cvpg_pkg;

    localparam int ATOM_BITS   = 16;
    localparam int IO_BITS     = 48;
    localparam int EN_BITS     = 47;
    localparam int WEIGHT_BITS = 24;

    localparam logic [4:0] COF_LAST  = 5'd17;
    localparam logic [4:0] VOL_LAST  = 5'd2;
    localparam logic [4:0] GRAD_LAST = 5'd11;
    localparam logic [4:0] EMIT_LAST = 5'd3;
    localparam logic [1:0] LAST_POINT = 2'd3;

    localparam logic signed [IO_BITS-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [IO_BITS-1:0] SAT_MIN = 48'sh8000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_COF_GO, S_COF_WAIT, S_COF3, S_VOL_GO, S_VOL_WAIT,
        S_CMP, S_PRE_GO, S_PRE_WAIT, S_EN_GO, S_EN_WAIT, S_GRAD_GO,
        S_GRAD_WAIT, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIFF, OP_COF_MUL, OP_COF_ST, OP_COF3, OP_VOL_MUL,
        OP_VOL_ST, OP_CMP, OP_PRE_MUL, OP_PRE_ST, OP_EN_MUL, OP_EN_ST,
        OP_GRAD_MUL, OP_GRAD_ST, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [3:0] ai;
        logic [3:0] bi;
    } t_cof_ops;

    typedef struct packed {
        logic [1:0] pt;
        logic [1:0] ax;
    } t_slot;

    function automatic logic [1:0] next3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    // Difference-vector entries multiplied by one cofactor product step.
    // Steps come in pairs: even step adds b[a+1]*c[a+2], odd subtracts b[a+2]*c[a+1].
    function automatic t_cof_ops cof_operands(input logic [4:0] idx);
        logic [1:0] k;
        logic [1:0] a;
        logic [1:0] br;
        logic [1:0] cr;
        logic [1:0] ax;
        logic [1:0] bx;
        t_cof_ops   r;
        case (idx[4:1])
            4'd0: begin k = 2'd0; a = 2'd0; end
            4'd1: begin k = 2'd0; a = 2'd1; end
            4'd2: begin k = 2'd0; a = 2'd2; end
            4'd3: begin k = 2'd1; a = 2'd0; end
            4'd4: begin k = 2'd1; a = 2'd1; end
            4'd5: begin k = 2'd1; a = 2'd2; end
            4'd6: begin k = 2'd2; a = 2'd0; end
            4'd7: begin k = 2'd2; a = 2'd1; end
            4'd8: begin k = 2'd2; a = 2'd2; end
            default: begin k = 2'd0; a = 2'd0; end
        endcase
        br = next3(k);
        cr = next3(br);
        if (!idx[0]) begin
            ax = next3(a);
            bx = next3(next3(a));
        end else begin
            ax = next3(next3(a));
            bx = next3(a);
        end
        r.ai = {1'b0, br, 1'b0} + {2'b00, br} + {2'b00, ax};
        r.bi = {1'b0, cr, 1'b0} + {2'b00, cr} + {2'b00, bx};
        return r;
    endfunction

    function automatic t_slot grad_slot(input logic [3:0] j);
        t_slot r;
        case (j)
            4'd0:  r = '{pt: 2'd0, ax: 2'd0};
            4'd1:  r = '{pt: 2'd0, ax: 2'd1};
            4'd2:  r = '{pt: 2'd0, ax: 2'd2};
            4'd3:  r = '{pt: 2'd1, ax: 2'd0};
            4'd4:  r = '{pt: 2'd1, ax: 2'd1};
            4'd5:  r = '{pt: 2'd1, ax: 2'd2};
            4'd6:  r = '{pt: 2'd2, ax: 2'd0};
            4'd7:  r = '{pt: 2'd2, ax: 2'd1};
            4'd8:  r = '{pt: 2'd2, ax: 2'd2};
            4'd9:  r = '{pt: 2'd3, ax: 2'd0};
            4'd10: r = '{pt: 2'd3, ax: 2'd1};
            4'd11: r = '{pt: 2'd3, ax: 2'd2};
            default: r = '{pt: 2'd0, ax: 2'd0};
        endcase
        return r;
    endfunction

endpackage

/* rtl/cvpg_smul.sv */
// Shift-add signed multiplier with accumulator, one multiplier bit per cycle.
`timescale 1ns / 1ps
module cvpg_smul #(
    parameter int PW = 188,
    parameter int BW = 81
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic                           i_clear,
    input  logic                           i_neg,
    input  logic [$clog2(BW+1)-1:0]        i_len,
    input  logic signed [PW-1:0]           i_a,
    input  logic signed [BW-1:0]           i_b,
    output logic signed [PW-1:0]           o_acc,
    output logic                           o_done
);
    localparam int LW = $clog2(BW+1);

    logic                  r_busy;
    logic                  r_done;
    logic [LW-1:0]         r_cnt;
    logic [LW-1:0]         r_len;
    logic                  r_neg;
    logic signed [PW-1:0]  r_a;
    logic [BW-1:0]         r_b;
    logic signed [PW-1:0]  r_acc;
    logic signed [PW-1:0]  w_term;
    logic                  w_last;
    logic signed [PW-1:0]  n_acc;

    // Top multiplier bit carries negative weight.
    assign w_last = (r_cnt == r_len - LW'(1));
    assign w_term = r_b[0] ? r_a : '0;
    assign n_acc  = (r_neg ^ w_last) ? r_acc - w_term : r_acc + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + LW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_len <= i_len;
            r_neg <= i_neg;
            if (i_clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

/* rtl/cvpg_dp.sv */
// Datapath: point store, difference vectors, cofactors, penalty and result registers.
`timescale 1ns / 1ps
`include "chiral_volume_penalty_gradient_assert.svh"
module cvpg_dp #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cvpg_pkg::t_cmd                      i_cmd,
    input  logic [cvpg_pkg::ATOM_BITS-1:0]      i_atom_index,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_lower,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_upper,
    input  logic [cvpg_pkg::WEIGHT_BITS-1:0]    i_weight,
    output logic                                o_mul_done,
    output logic                                o_valid,
    output logic [cvpg_pkg::ATOM_BITS-1:0]      o_out_atom,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_x,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_y,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_z,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_volume,
    output logic [cvpg_pkg::EN_BITS-1:0]        o_energy,
    output logic                                o_violated,
    output logic                                o_last
);
    localparam int VW    = COORD_BITS + 1;
    localparam int CW    = 2 * VW + 1;
    localparam int CXW   = CW + 2;
    localparam int VOLW  = VW + CXW + 2;
    localparam int BNDW  = cvpg_pkg::IO_BITS + 2 * FRAC_BITS;
    localparam int DW    = ((VOLW > BNDW) ? VOLW : BNDW) + 1;
    localparam int WTW   = cvpg_pkg::WEIGHT_BITS + 1;
    localparam int PREW  = DW + WTW;
    localparam int PW    = PREW + DW;
    localparam int LW    = $clog2(DW + 1);
    localparam int IOW   = cvpg_pkg::IO_BITS;

    logic signed [COORD_BITS-1:0]  r_hc [9];
    logic signed [COORD_BITS-1:0]  r_p4 [3];
    logic [cvpg_pkg::ATOM_BITS-1:0] r_ha [3];
    logic [cvpg_pkg::ATOM_BITS-1:0] r_atom4;
    logic signed [IOW-1:0]         r_lower;
    logic signed [IOW-1:0]         r_upper;
    logic [cvpg_pkg::WEIGHT_BITS-1:0] r_weight;
    logic signed [VW-1:0]          r_va [9];
    logic signed [VW-1:0]          r_vb [9];
    logic signed [CXW-1:0]         r_cof [12];
    logic signed [VOLW-1:0]        r_vol;
    logic signed [IOW-1:0]         r_vol_o;
    logic signed [DW-1:0]          r_diff;
    logic                          r_viol;
    logic signed [PREW-1:0]        r_pre;
    logic [cvpg_pkg::EN_BITS-1:0]  r_en;
    logic signed [IOW-1:0]         r_gx [4];
    logic signed [IOW-1:0]         r_gy [4];
    logic signed [IOW-1:0]         r_gz [4];

    logic                          r_valid;
    logic [cvpg_pkg::ATOM_BITS-1:0] r_o_atom;
    logic signed [IOW-1:0]         r_o_gx;
    logic signed [IOW-1:0]         r_o_gy;
    logic signed [IOW-1:0]         r_o_gz;
    logic signed [IOW-1:0]         r_o_vol;
    logic [cvpg_pkg::EN_BITS-1:0]  r_o_energy;
    logic                          r_o_viol;
    logic                          r_o_last;

    cvpg_pkg::t_cof_ops            w_ops;
    cvpg_pkg::t_slot               w_slot;
    logic                          w_go;
    logic                          w_clear;
    logic                          w_neg;
    logic [LW-1:0]                 w_len;
    logic signed [PW-1:0]          w_a;
    logic signed [DW-1:0]          w_b;
    logic signed [PW-1:0]          w_acc;
    logic signed [CXW-1:0]         w_cof_rd;
    logic signed [DW-1:0]          w_volx;
    logic signed [DW-1:0]          w_lo;
    logic signed [DW-1:0]          w_hi;
    logic signed [DW-1:0]          w_diff;
    logic                          w_viol;
    logic signed [IOW-1:0]         w_vol_r;
    logic signed [IOW-1:0]         w_en_r;
    logic signed [IOW-1:0]         w_grad_r;

    // Round to nearest, ties up, by k bits, then saturate to 48 signed bits.
    function automatic logic signed [IOW-1:0] round_sat(input logic signed [PW-1:0] a,
                                                        input int k);
        logic signed [PW:0] t;
        logic signed [PW:0] s;
        logic signed [PW:0] smax;
        logic signed [PW:0] smin;
        logic signed [IOW-1:0] r;
        smax = (PW+1)'(cvpg_pkg::SAT_MAX);
        smin = (PW+1)'(cvpg_pkg::SAT_MIN);
        t = (PW+1)'(a) + ((PW+1)'(1) << (k - 1));
        s = t >>> k;
        if (s > smax) begin
            r = cvpg_pkg::SAT_MAX;
        end else if (s < smin) begin
            r = cvpg_pkg::SAT_MIN;
        end else begin
            r = s[IOW-1:0];
        end
        return r;
    endfunction

    cvpg_smul #(
        .PW (PW),
        .BW (DW)
    ) u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_clear (w_clear),
        .i_neg   (w_neg),
        .i_len   (w_len),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc),
        .o_done  (o_mul_done)
    );

    assign w_cof_rd = r_cof[i_cmd.idx[3:0]];
    assign w_slot   = cvpg_pkg::grad_slot(i_cmd.idx[3:0]);

    always_comb begin
        w_ops   = cvpg_pkg::cof_operands(i_cmd.idx);
        w_go    = 1'b0;
        w_clear = 1'b0;
        w_neg   = 1'b0;
        w_len   = '0;
        w_a     = '0;
        w_b     = '0;
        case (i_cmd.op)
            cvpg_pkg::OP_COF_MUL: begin
                w_go    = 1'b1;
                w_clear = !i_cmd.idx[0];
                w_neg   = i_cmd.idx[0];
                w_len   = LW'(VW);
                w_a     = PW'(r_va[w_ops.ai]);
                w_b     = DW'(r_vb[w_ops.bi]);
            end
            cvpg_pkg::OP_VOL_MUL: begin
                w_go    = 1'b1;
                w_clear = (i_cmd.idx == 5'd0);
                w_len   = LW'(VW);
                w_a     = PW'(w_cof_rd);
                w_b     = DW'(r_va[i_cmd.idx[3:0]]);
            end
            cvpg_pkg::OP_PRE_MUL: begin
                w_go    = 1'b1;
                w_clear = 1'b1;
                w_len   = LW'(WTW);
                w_a     = PW'(r_diff);
                w_b     = DW'(r_weight);
            end
            cvpg_pkg::OP_EN_MUL: begin
                w_go    = 1'b1;
                w_clear = 1'b1;
                w_len   = LW'(DW);
                w_a     = PW'(r_pre);
                w_b     = r_diff;
            end
            cvpg_pkg::OP_GRAD_MUL: begin
                w_go    = 1'b1;
                w_clear = 1'b1;
                w_len   = LW'(CXW);
                w_a     = PW'(r_pre);
                w_b     = DW'(w_cof_rd);
            end
            default: begin
            end
        endcase
    end

    // Flat-bottom test on the exact volume; the lower bound wins when bounds cross.
    assign w_volx = DW'(r_vol);
    assign w_lo   = DW'(r_lower) <<< (2 * FRAC_BITS);
    assign w_hi   = DW'(r_upper) <<< (2 * FRAC_BITS);

    always_comb begin
        w_diff = '0;
        w_viol = 1'b0;
        if (w_volx < w_lo) begin
            w_diff = w_volx - w_lo;
            w_viol = 1'b1;
        end else if (w_hi < w_volx) begin
            w_diff = w_volx - w_hi;
            w_viol = 1'b1;
        end
    end

    assign w_vol_r  = round_sat(w_acc, 2 * FRAC_BITS);
    assign w_en_r   = round_sat(w_acc, 6 * FRAC_BITS);
    assign w_grad_r = round_sat(w_acc, 5 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cvpg_pkg::OP_LOAD: begin
                if (i_cmd.idx[1:0] == cvpg_pkg::LAST_POINT) begin
                    r_p4[0]  <= i_pos_x;
                    r_p4[1]  <= i_pos_y;
                    r_p4[2]  <= i_pos_z;
                    r_atom4  <= i_atom_index;
                    r_lower  <= i_vol_lower;
                    r_upper  <= i_vol_upper;
                    r_weight <= i_weight;
                end
                for (int p = 0; p < 3; p++) begin
                    if (i_cmd.idx[1:0] == 2'(p)) begin
                        r_hc[p*3]   <= i_pos_x;
                        r_hc[p*3+1] <= i_pos_y;
                        r_hc[p*3+2] <= i_pos_z;
                        r_ha[p]     <= i_atom_index;
                    end
                end
            end
            cvpg_pkg::OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    for (int a = 0; a < 3; a++) begin
                        r_va[k*3+a] <= VW'(r_hc[k*3+a]) - VW'(r_p4[a]);
                        r_vb[k*3+a] <= VW'(r_hc[k*3+a]) - VW'(r_p4[a]);
                    end
                end
            end
            cvpg_pkg::OP_COF_ST: begin
                r_cof[i_cmd.idx[4:1]] <= w_acc[CXW-1:0];
            end
            cvpg_pkg::OP_COF3: begin
                for (int a = 0; a < 3; a++) begin
                    r_cof[9+a] <= -(r_cof[a] + r_cof[3+a] + r_cof[6+a]);
                end
            end
            cvpg_pkg::OP_VOL_ST: begin
                r_vol   <= w_acc[VOLW-1:0];
                r_vol_o <= w_vol_r;
            end
            cvpg_pkg::OP_CMP: begin
                r_diff <= w_diff;
                r_viol <= w_viol;
            end
            cvpg_pkg::OP_PRE_ST: begin
                r_pre <= w_acc[PREW-1:0];
            end
            cvpg_pkg::OP_EN_ST: begin
                r_en <= w_en_r[cvpg_pkg::EN_BITS-1:0];
            end
            cvpg_pkg::OP_GRAD_ST: begin
                case (w_slot.ax)
                    2'd0:    r_gx[w_slot.pt] <= w_grad_r;
                    2'd1:    r_gy[w_slot.pt] <= w_grad_r;
                    default: r_gz[w_slot.pt] <= w_grad_r;
                endcase
            end
            cvpg_pkg::OP_EMIT: begin
                r_o_atom   <= (i_cmd.idx[1:0] == cvpg_pkg::LAST_POINT) ? r_atom4
                                                                      : r_ha[i_cmd.idx[1:0]];
                r_o_gx     <= r_gx[i_cmd.idx[1:0]];
                r_o_gy     <= r_gy[i_cmd.idx[1:0]];
                r_o_gz     <= r_gz[i_cmd.idx[1:0]];
                r_o_vol    <= r_vol_o;
                r_o_energy <= r_en;
                r_o_viol   <= r_viol;
                r_o_last   <= (i_cmd.idx == cvpg_pkg::EMIT_LAST);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == cvpg_pkg::OP_EMIT);
        end
    end

    assign o_valid    = r_valid;
    assign o_out_atom = r_o_atom;
    assign o_grad_x   = r_o_gx;
    assign o_grad_y   = r_o_gy;
    assign o_grad_z   = r_o_gz;
    assign o_volume   = r_o_vol;
    assign o_energy   = r_o_energy;
    assign o_violated = r_o_viol;
    assign o_last     = r_o_last;

    `CVPG_ASSERT_NOW(a_energy_only_when_violated, r_valid, r_o_viol || (r_o_energy == '0), "energy without violation")
    `CVPG_ASSERT_NOW(a_last_follows_run, r_valid && r_o_last, $past(r_valid), "last result not in a run")
    `CVPG_ASSERT_NOW(a_flat_when_within, r_valid && !r_o_viol, (r_o_gx == '0) && (r_o_gy == '0) && (r_o_gz == '0), "gradient within bounds")

endmodule

/* rtl/cvpg_ctrl.sv */
// Controller: collects four points and sequences the penalty computation.
`timescale 1ns / 1ps
`include "chiral_volume_penalty_gradient_assert.svh"
module cvpg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mul_done,
    output logic           o_busy,
    output cvpg_pkg::t_cmd o_cmd
);
    cvpg_pkg::t_state r_state;
    cvpg_pkg::t_state n_state;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic [4:0]       r_idx;
    logic [4:0]       n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvpg_pkg::S_IDLE;
            r_cnt   <= 2'd0;
            r_idx   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        case (r_state)
            cvpg_pkg::S_IDLE: begin
                if (i_start) begin
                    if (r_cnt == cvpg_pkg::LAST_POINT) begin
                        n_cnt   = 2'd0;
                        n_state = cvpg_pkg::S_DIFF;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            cvpg_pkg::S_DIFF: begin
                n_idx   = 5'd0;
                n_state = cvpg_pkg::S_COF_GO;
            end
            cvpg_pkg::S_COF_GO:   n_state = cvpg_pkg::S_COF_WAIT;
            cvpg_pkg::S_COF_WAIT: begin
                if (i_mul_done) begin
                    if (r_idx == cvpg_pkg::COF_LAST) begin
                        n_idx   = 5'd0;
                        n_state = cvpg_pkg::S_COF3;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = cvpg_pkg::S_COF_GO;
                    end
                end
            end
            cvpg_pkg::S_COF3:     n_state = cvpg_pkg::S_VOL_GO;
            cvpg_pkg::S_VOL_GO:   n_state = cvpg_pkg::S_VOL_WAIT;
            cvpg_pkg::S_VOL_WAIT: begin
                if (i_mul_done) begin
                    if (r_idx == cvpg_pkg::VOL_LAST) begin
                        n_idx   = 5'd0;
                        n_state = cvpg_pkg::S_CMP;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = cvpg_pkg::S_VOL_GO;
                    end
                end
            end
            cvpg_pkg::S_CMP:      n_state = cvpg_pkg::S_PRE_GO;
            cvpg_pkg::S_PRE_GO:   n_state = cvpg_pkg::S_PRE_WAIT;
            cvpg_pkg::S_PRE_WAIT: begin
                if (i_mul_done) begin
                    n_state = cvpg_pkg::S_EN_GO;
                end
            end
            cvpg_pkg::S_EN_GO:    n_state = cvpg_pkg::S_EN_WAIT;
            cvpg_pkg::S_EN_WAIT: begin
                if (i_mul_done) begin
                    n_idx   = 5'd0;
                    n_state = cvpg_pkg::S_GRAD_GO;
                end
            end
            cvpg_pkg::S_GRAD_GO:  n_state = cvpg_pkg::S_GRAD_WAIT;
            cvpg_pkg::S_GRAD_WAIT: begin
                if (i_mul_done) begin
                    if (r_idx == cvpg_pkg::GRAD_LAST) begin
                        n_idx   = 5'd0;
                        n_state = cvpg_pkg::S_EMIT;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = cvpg_pkg::S_GRAD_GO;
                    end
                end
            end
            cvpg_pkg::S_EMIT: begin
                if (r_idx == cvpg_pkg::EMIT_LAST) begin
                    n_idx   = 5'd0;
                    n_state = cvpg_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            default: n_state = cvpg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = (r_state != cvpg_pkg::S_IDLE);
        o_cmd.op  = cvpg_pkg::OP_NONE;
        o_cmd.idx = r_idx;
        case (r_state)
            cvpg_pkg::S_IDLE: begin
                o_cmd.idx = {3'b000, r_cnt};
                if (i_start) begin
                    o_cmd.op = cvpg_pkg::OP_LOAD;
                end
            end
            cvpg_pkg::S_DIFF:     o_cmd.op = cvpg_pkg::OP_DIFF;
            cvpg_pkg::S_COF_GO:   o_cmd.op = cvpg_pkg::OP_COF_MUL;
            cvpg_pkg::S_COF_WAIT: begin
                if (i_mul_done && r_idx[0]) begin
                    o_cmd.op = cvpg_pkg::OP_COF_ST;
                end
            end
            cvpg_pkg::S_COF3:     o_cmd.op = cvpg_pkg::OP_COF3;
            cvpg_pkg::S_VOL_GO:   o_cmd.op = cvpg_pkg::OP_VOL_MUL;
            cvpg_pkg::S_VOL_WAIT: begin
                if (i_mul_done && (r_idx == cvpg_pkg::VOL_LAST)) begin
                    o_cmd.op = cvpg_pkg::OP_VOL_ST;
                end
            end
            cvpg_pkg::S_CMP:      o_cmd.op = cvpg_pkg::OP_CMP;
            cvpg_pkg::S_PRE_GO:   o_cmd.op = cvpg_pkg::OP_PRE_MUL;
            cvpg_pkg::S_PRE_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.op = cvpg_pkg::OP_PRE_ST;
                end
            end
            cvpg_pkg::S_EN_GO:    o_cmd.op = cvpg_pkg::OP_EN_MUL;
            cvpg_pkg::S_EN_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.op = cvpg_pkg::OP_EN_ST;
                end
            end
            cvpg_pkg::S_GRAD_GO:  o_cmd.op = cvpg_pkg::OP_GRAD_MUL;
            cvpg_pkg::S_GRAD_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.op = cvpg_pkg::OP_GRAD_ST;
                end
            end
            cvpg_pkg::S_EMIT:     o_cmd.op = cvpg_pkg::OP_EMIT;
            default:              o_cmd.op = cvpg_pkg::OP_NONE;
        endcase
    end

    `CVPG_ASSERT_NOW(a_cof_store_on_done, o_cmd.op == cvpg_pkg::OP_COF_ST, i_mul_done, "cofactor stored before product done")
    `CVPG_ASSERT_NEXT(a_emit_returns_idle, (r_state == cvpg_pkg::S_EMIT) && (r_idx == cvpg_pkg::EMIT_LAST), !o_busy, "block stays busy after last result")
    `CVPG_ASSERT_NEXT(a_fourth_point_starts, i_start && !o_busy && (r_cnt == cvpg_pkg::LAST_POINT), o_busy, "fourth point did not start computation")

endmodule

/* rtl/chiral_volume_penalty_gradient.sv */
// Top level of the chiral volume flat-bottom penalty and gradient block.
`timescale 1ns / 1ps
// Feed the four points of one chiral contribution one request at a time:
// a request is taken at a rising edge with start high and busy low. The
// first three points are held; the fourth also supplies the volume bounds
// and the weight, and starts the computation. After the fourth, busy stays
// high while one shared shift-add multiplier (one multiplier bit per cycle)
// forms, in order, the 18 cofactor products, the three volume products, the
// pre-factor, the energy and the 12 gradient products. Then four results
// leave on consecutive cycles, each marked by o_valid for exactly one
// cycle, o_last on the fourth. The receiver cannot stall: take each result
// on the cycle it is shown. A new point request is taken as early as the
// cycle in which the last result shows.
module chiral_volume_penalty_gradient #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cvpg_pkg::ATOM_BITS-1:0]      i_atom_index,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_lower,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_upper,
    input  logic [cvpg_pkg::WEIGHT_BITS-1:0]    i_weight,
    output logic                                o_valid,
    output logic [cvpg_pkg::ATOM_BITS-1:0]      o_out_atom,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_x,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_y,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_z,
    output logic signed [cvpg_pkg::IO_BITS-1:0] o_volume,
    output logic [cvpg_pkg::EN_BITS-1:0]        o_energy,
    output logic                                o_violated,
    output logic                                o_last
);
    cvpg_pkg::t_cmd w_cmd;
    logic           w_mul_done;

    // Sequence points and computation steps; busy comes straight from here.
    cvpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_mul_done (w_mul_done),
        .o_busy     (busy),
        .o_cmd      (w_cmd)
    );

    // Hold the points, run the arithmetic and drive the result registers.
    cvpg_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_atom_index (i_atom_index),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_vol_lower  (i_vol_lower),
        .i_vol_upper  (i_vol_upper),
        .i_weight     (i_weight),
        .o_mul_done   (w_mul_done),
        .o_valid      (o_valid),
        .o_out_atom   (o_out_atom),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_grad_z     (o_grad_z),
        .o_volume     (o_volume),
        .o_energy     (o_energy),
        .o_violated   (o_violated),
        .o_last       (o_last)
    );

endmodule

/* dv/cvpg_checker.sv */
// Checker that predicts and compares the chiral volume penalty results.
`timescale 1ns / 1ps
module cvpg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [cvpg_pkg::ATOM_BITS-1:0]      i_atom_index,
    input  logic signed [23:0]                  i_pos_x,
    input  logic signed [23:0]                  i_pos_y,
    input  logic signed [23:0]                  i_pos_z,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_lower,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] i_vol_upper,
    input  logic [cvpg_pkg::WEIGHT_BITS-1:0]    i_weight,
    input  logic                                o_valid,
    input  logic [cvpg_pkg::ATOM_BITS-1:0]      o_out_atom,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_x,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_y,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] o_grad_z,
    input  logic signed [cvpg_pkg::IO_BITS-1:0] o_volume,
    input  logic [cvpg_pkg::EN_BITS-1:0]        o_energy,
    input  logic                                o_violated,
    input  logic                                o_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import cvpg_pkg::*;

    localparam int FRAC = 16;

    typedef logic signed [287:0] t_wide;

    typedef struct {
        logic [ATOM_BITS-1:0]      atom;
        logic signed [IO_BITS-1:0] gx;
        logic signed [IO_BITS-1:0] gy;
        logic signed [IO_BITS-1:0] gz;
        logic signed [IO_BITS-1:0] vol;
        logic [EN_BITS-1:0]        en;
        logic                      viol;
        logic                      last;
    } t_grad_rec;

    t_grad_rec             grad_q[$];
    logic [1:0]            pts_seen;
    logic signed [23:0]    pt_xyz[3][3];
    logic [ATOM_BITS-1:0]  pt_atom[3];

    initial begin
        o_fail_count = 0;
        pts_seen     = 2'd0;
    end

    assign o_pending = grad_q.size();

    // Round to nearest (ties up), drop k bits, clamp to 48 signed bits.
    function automatic logic signed [IO_BITS-1:0] round_sat(input t_wide a, input int k);
        t_wide r;
        r = (a + (t_wide'(1) <<< (k - 1))) >>> k;
        if (r > t_wide'(SAT_MAX)) return SAT_MAX;
        if (r < t_wide'(SAT_MIN)) return SAT_MIN;
        return r[IO_BITS-1:0];
    endfunction

    task automatic predict_gradients(input logic [ATOM_BITS-1:0] atom4,
                                     input logic signed [23:0] x4,
                                     input logic signed [23:0] y4,
                                     input logic signed [23:0] z4,
                                     input logic signed [IO_BITS-1:0] lo_b,
                                     input logic signed [IO_BITS-1:0] hi_b,
                                     input logic [WEIGHT_BITS-1:0] wt);
        t_wide     dv[3][3];
        t_wide     cof[4][3];
        t_wide     p4[3];
        t_wide     vol, lo, hi, diff, pre;
        logic      viol;
        t_grad_rec rec;
        int        b, c;
        p4[0] = x4;
        p4[1] = y4;
        p4[2] = z4;
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++) dv[k][a] = t_wide'(pt_xyz[k][a]) - p4[a];
        // cofactor k = v[k+1] x v[k+2]
        for (int k = 0; k < 3; k++) begin
            b = (k + 1) % 3;
            c = (k + 2) % 3;
            cof[k][0] = dv[b][1] * dv[c][2] - dv[b][2] * dv[c][1];
            cof[k][1] = dv[b][2] * dv[c][0] - dv[b][0] * dv[c][2];
            cof[k][2] = dv[b][0] * dv[c][1] - dv[b][1] * dv[c][0];
        end
        for (int a = 0; a < 3; a++) cof[3][a] = -(cof[0][a] + cof[1][a] + cof[2][a]);
        vol = dv[0][0] * cof[0][0] + dv[0][1] * cof[0][1] + dv[0][2] * cof[0][2];
        lo = t_wide'(lo_b) <<< (2 * FRAC);
        hi = t_wide'(hi_b) <<< (2 * FRAC);
        diff = '0;
        viol = 1'b0;
        // lower bound wins when the bounds are crossed
        if (vol < lo) begin
            diff = vol - lo;
            viol = 1'b1;
        end else if (vol > hi) begin
            diff = vol - hi;
            viol = 1'b1;
        end
        pre = t_wide'({1'b0, wt}) * diff;
        rec.vol  = round_sat(vol, 2 * FRAC);
        rec.en   = EN_BITS'(round_sat(pre * diff, 6 * FRAC));
        rec.viol = viol;
        for (int k = 0; k < 4; k++) begin
            rec.atom = (k < 3) ? pt_atom[k] : atom4;
            rec.gx   = round_sat(pre * cof[k][0], 5 * FRAC);
            rec.gy   = round_sat(pre * cof[k][1], 5 * FRAC);
            rec.gz   = round_sat(pre * cof[k][2], 5 * FRAC);
            rec.last = (k == 3);
            grad_q.push_back(rec);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Capture accepted requests.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (pts_seen < LAST_POINT) begin
                pt_atom[pts_seen]   = i_atom_index;
                pt_xyz[pts_seen][0] = i_pos_x;
                pt_xyz[pts_seen][1] = i_pos_y;
                pt_xyz[pts_seen][2] = i_pos_z;
                pts_seen++;
            end else begin
                predict_gradients(i_atom_index, i_pos_x, i_pos_y, i_pos_z,
                                  i_vol_lower, i_vol_upper, i_weight);
                pts_seen = 2'd0;
            end
        end
    end

    // Compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_grad_rec want;
        if (i_rst_n && o_valid) begin
            if (grad_q.size() == 0) begin
                report_mismatch("unexpected result", {48'b0, o_out_atom}, '0);
            end else begin
                want = grad_q.pop_front();
                if (o_out_atom !== want.atom) report_mismatch("atom", o_out_atom, want.atom);
                if (o_grad_x !== want.gx) report_mismatch("grad_x", o_grad_x, want.gx);
                if (o_grad_y !== want.gy) report_mismatch("grad_y", o_grad_y, want.gy);
                if (o_grad_z !== want.gz) report_mismatch("grad_z", o_grad_z, want.gz);
                if (o_volume !== want.vol) report_mismatch("volume", o_volume, want.vol);
                if (o_energy !== want.en) report_mismatch("energy", o_energy, want.en);
                if (o_violated !== want.viol)
                    report_mismatch("violated", o_violated, want.viol);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

endmodule

/* dv/tb_chiral_volume_penalty_gradient.sv */
// Testbench top: stimulus, reset, timeout and verdict for the chiral volume block.
`timescale 1ns / 1ps
module tb_chiral_volume_penalty_gradient;
    import cvpg_pkg::*;

    localparam int  RAND_ITEMS = 260;
    // Bound on the whole run: every contribution plus gaps, many times over
    localparam int  CYCLE_LIMIT = 2000000;
    localparam logic signed [23:0] C_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] C_MIN = 24'sh80_0000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [ATOM_BITS-1:0]        i_atom_index = '0;
    logic signed [23:0]          i_pos_x = '0;
    logic signed [23:0]          i_pos_y = '0;
    logic signed [23:0]          i_pos_z = '0;
    logic signed [IO_BITS-1:0]   i_vol_lower = '0;
    logic signed [IO_BITS-1:0]   i_vol_upper = '0;
    logic [WEIGHT_BITS-1:0]      i_weight = '0;
    logic                        o_valid;
    logic [ATOM_BITS-1:0]        o_out_atom;
    logic signed [IO_BITS-1:0]   o_grad_x, o_grad_y, o_grad_z, o_volume;
    logic [EN_BITS-1:0]          o_energy;
    logic                        o_violated, o_last;
    int                          fail_count;
    int                          pending;
    int                          cycles = 0;
    int                          burst_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    chiral_volume_penalty_gradient dut (.*);

    cvpg_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_atom_index, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_vol_lower, .i_vol_upper, .i_weight, .o_valid, .o_out_atom, .o_grad_x,
        .o_grad_y, .o_grad_z, .o_volume, .o_energy, .o_violated, .o_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("chiral_volume_penalty_gradient regression: fail");
            $finish;
        end
    end

    // Drive one request and hold it until the block takes it.
    task automatic send_point(input logic [15:0] atom, input logic signed [23:0] x,
                              input logic signed [23:0] y, input logic signed [23:0] z,
                              input logic signed [47:0] lo, input logic signed [47:0] hi,
                              input logic [23:0] wt);
        start        <= 1'b1;
        i_atom_index <= atom;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_z      <= z;
        i_vol_lower  <= lo;
        i_vol_upper  <= hi;
        i_weight     <= wt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Sender runs in bursts; a gap between bursts drops start for a random stretch.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
            2: return ($urandom_range(0, 1)) ? C_MAX : C_MIN;
            default: return $signed(24'($urandom_range(0, 1 << 19))) - 24'sd262144;
        endcase
    endfunction

    function automatic logic signed [47:0] rand_bound();
        logic signed [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >>> $urandom_range(4, 40);
            2: return ($urandom_range(0, 1)) ? SAT_MAX : SAT_MIN;
            default: return 48'sd0;
        endcase
    endfunction

    initial begin
        logic signed [47:0] lo, hi, t;
        logic [23:0]        wt;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flat geometry, zero bounds: within bounds, zero volume
        repeat (4) send_point(16'h0000, 24'sd0, 24'sd0, 24'sd0, 48'sd0, 48'sd0, 24'hFF_FFFF);
        // extreme corners, bound far above the volume: below, saturating
        send_point(16'hFFFF, C_MAX, 24'sd0, 24'sd0, '0, '0, '0);
        send_point(16'h0001, 24'sd0, C_MAX, 24'sd0, '0, '0, '0);
        send_point(16'h8000, 24'sd0, 24'sd0, C_MAX, '0, '0, '0);
        send_point(16'hFFFF, C_MIN, C_MIN, C_MIN, SAT_MAX, SAT_MAX, 24'hFF_FFFF);
        // same corners, bound far below: above the upper bound
        send_point(16'h1234, C_MAX, 24'sd0, 24'sd0, '0, '0, '0);
        send_point(16'h5678, 24'sd0, C_MAX, 24'sd0, '0, '0, '0);
        send_point(16'h9ABC, 24'sd0, 24'sd0, C_MAX, '0, '0, '0);
        send_point(16'hDEF0, C_MIN, C_MIN, C_MIN, SAT_MIN, SAT_MIN, 24'hFF_FFFF);
        // crossed bounds, then violation with zero weight
        send_point(16'h0002, C_MIN, C_MAX, C_MIN, '0, '0, '0);
        send_point(16'h0003, C_MAX, C_MIN, C_MAX, '0, '0, '0);
        send_point(16'h0004, C_MAX, C_MAX, C_MIN, '0, '0, '0);
        send_point(16'h0005, 24'sd0, 24'sd0, 24'sd0, SAT_MAX, SAT_MIN, 24'h00_0001);
        send_point(16'h0006, 24'sd65536, 24'sd0, 24'sd0, '1, '1, '1);
        send_point(16'h0007, 24'sd0, 24'sd65536, 24'sd0, '1, '1, '1);
        send_point(16'h0008, 24'sd0, 24'sd0, 24'sd65536, '1, '1, '1);
        send_point(16'h0009, 24'sd0, 24'sd0, 24'sd0, 48'sd1 <<< 20, 48'sd1 <<< 22, 24'h0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            pace_sender();
            // right after a fourth point, let the block drain completely once
            if (n == (RAND_ITEMS / 8) * 4) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            lo = rand_bound();
            hi = rand_bound();
            if ($urandom_range(0, 4) != 0 && lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            wt = ($urandom_range(0, 5) == 0) ? 24'hFF_FFFF : 24'($urandom);
            send_point(16'($urandom), rand_coord(), rand_coord(), rand_coord(), lo, hi, wt);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("chiral_volume_penalty_gradient regression: pass");
        end else begin
            $display("chiral_volume_penalty_gradient regression: fail");
        end
        $finish;
    end

endmodule
